// File: src/sha256_hash_engine_core_assert.svh
// Assertion macros for the SHA-256 engine
`ifndef SHA256_HASH_ENGINE_CORE_ASSERT_SVH
`define SHA256_HASH_ENGINE_CORE_ASSERT_SVH

// Implication that must hold while out of reset
`define SHA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication while out of reset
`define SHA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and round functions for the SHA-256 engine.
// ----------------------------------------------------------------------------
`default_nettype none
package sha_pkg;

  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned ROUNDS      = 64;
  localparam int unsigned LEN_BITS    = 61;
  localparam logic [5:0]  PAD_LEN_POS = 6'd56;
  localparam logic [7:0]  PAD_BYTE    = 8'h80;

  localparam logic REQ_BYTE   = 1'b0;
  localparam logic REQ_FINISH = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
  } sha_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha_out_t;

  // Compression control between sequencer and round unit
  typedef struct packed {
    logic       start;
    logic       reinit;
  } rnd_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rnd_sts_t;

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[t];
  endfunction

  function automatic logic [31:0] ror32(input logic [31:0] v, input int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

endpackage
`default_nettype wire

// File: src/sha_round.sv
// ----------------------------------------------------------------------------
// sha_round
// Shared round unit: one SHA-256 round per cycle over all 64 rounds, with the
// rolling 16-word schedule and the eight chaining words.
// ----------------------------------------------------------------------------
`default_nettype none
module sha_round
  import sha_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire rnd_ctl_t    ctl,
  input  wire logic [31:0] blk_word [16],
  input  wire logic [2:0]  rd_idx,
  output logic [31:0]      rd_word,
  output rnd_sts_t         sts
);

  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [31:0] w_r [16];
  logic [5:0]  t_r;
  logic        busy_r;
  logic        done_r;

  // schedule word for this round
  logic [31:0] s0, s1, w_new, w_cur;
  logic [31:0] sig1, ch, t1, sig0, maj;

  always_comb begin
    s0    = ror32(w_r[1], 7) ^ ror32(w_r[1], 18) ^ (w_r[1] >> 3);
    s1    = ror32(w_r[14], 17) ^ ror32(w_r[14], 19) ^ (w_r[14] >> 10);
    w_new = w_r[0] + s0 + w_r[9] + s1;
    w_cur = (t_r < 6'd16) ? w_r[0] : w_new;
    sig1  = ror32(v_r[4], 6) ^ ror32(v_r[4], 11) ^ ror32(v_r[4], 25);
    ch    = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1    = v_r[7] + sig1 + ch + round_k(t_r) + w_cur;
    sig0  = ror32(v_r[0], 2) ^ ror32(v_r[0], 13) ^ ror32(v_r[0], 22);
    maj   = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  end

  assign rd_word  = h_r[rd_idx];
  assign sts.busy = busy_r;
  assign sts.done = done_r;

  // round sequencing, schedule window shifts by one word per round
  always_ff @(posedge clk) begin
    done_r <= 1'b0;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      t_r    <= '0;
      h_r    <= H_INIT;
    end else if (ctl.reinit) begin
      h_r <= H_INIT;
    end else if (ctl.start && !busy_r) begin
      busy_r <= 1'b1;
      t_r    <= '0;
      w_r    <= blk_word;
      v_r    <= h_r;
    end else if (busy_r) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= w_cur;
      v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
      v_r[0] <= t1 + sig0 + maj;
      t_r <= t_r + 6'd1;
      if (t_r == 6'(ROUNDS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else if (done_r) begin
      for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
    end
  end

  `include "sha256_hash_engine_core_assert.svh"
  `SHA_ASSERT_NXT(a_start_busy, ctl.start && !busy_r && !ctl.reinit, busy_r)
  `SHA_ASSERT_IMP(a_done_not_busy, done_r, !busy_r)
  `SHA_ASSERT_NXT(a_last_round, busy_r && t_r == 6'(ROUNDS - 1), done_r && !busy_r)

endmodule
`default_nettype wire

// File: src/sha256_hash_engine_core.sv
// ----------------------------------------------------------------------------
// sha256_hash_engine_core
// SHA-256 over a byte stream; a finish request pads and emits the digest.
//
//   channel | dir | payload   | handshake
//   in_     | in  | sha_in_t  | in_valid / in_stall
//   out_    | out | sha_out_t | out_valid / out_stall
//
// A byte request is taken at once unless it completes a block; the 64th byte
// of a block holds the input through a start cycle, the 64 rounds, a fold
// cycle and a return to idle.
// A finish request feeds padding one byte a cycle through the same buffer,
// compresses once or twice, then presents eight words on out_.
// Reset is synchronous; out_stall holds the current word.
// ----------------------------------------------------------------------------
`default_nettype none
module sha256_hash_engine_core
  import sha_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire sha_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output sha_out_t      out_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_COMP, S_PAD, S_EMIT
  } state_t;

  state_t      state_r;
  logic [31:0] blk_r [16];
  logic [5:0]  fill_r;
  logic [LEN_BITS-1:0] total_r;
  logic        fin_r;
  logic        len_blk_r;
  logic [63:0] bits_r;
  logic [2:0]  widx_r;
  logic        ovalid_r;
  logic        go_r;
  logic        reinit_r;

  rnd_ctl_t    ctl;
  rnd_sts_t    sts;
  logic [31:0] rd_word;

  assign ctl.start  = go_r;
  assign ctl.reinit = reinit_r;

  sha_round u_round (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .blk_word(blk_r),
    .rd_idx(widx_r), .rd_word(rd_word), .sts(sts));

  // padding byte for current fill position; length only in the last block
  logic [7:0] pad_byte;
  always_comb begin
    if (fill_r < PAD_LEN_POS || !len_blk_r) pad_byte = 8'h00;
    else pad_byte = bits_r[8*(7 - 3'(fill_r - PAD_LEN_POS)) +: 8];
  end

  logic in_acc;
  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = ovalid_r;
  assign out_data.digest_word = rd_word;
  assign out_data.word_index  = widx_r;
  assign out_data.last_word   = (widx_r == 3'd7);

  // request sequencer: buffering, padding, compression, digest output
  always_ff @(posedge clk) begin
    go_r     <= 1'b0;
    reinit_r <= 1'b0;
    if (!rst_n) begin
      state_r   <= S_IDLE;
      fill_r    <= '0;
      total_r   <= '0;
      fin_r     <= 1'b0;
      len_blk_r <= 1'b0;
      widx_r    <= '0;
      ovalid_r  <= 1'b0;
      go_r      <= 1'b0;
      reinit_r  <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_data.req_type == REQ_BYTE) begin
              blk_r[fill_r[5:2]][{~fill_r[1:0], 3'b000} +: 8] <= in_data.data_byte;
              fill_r  <= fill_r + 6'd1;
              total_r <= total_r + LEN_BITS'(1);
              if (fill_r == 6'(BLOCK_BYTES - 1)) begin
                go_r    <= 1'b1;
                fin_r   <= 1'b0;
                state_r <= S_COMP;
              end
            end else begin
              bits_r <= {total_r, 3'b000};
              blk_r[fill_r[5:2]][{~fill_r[1:0], 3'b000} +: 8] <= PAD_BYTE;
              fill_r    <= fill_r + 6'd1;
              fin_r     <= 1'b1;
              len_blk_r <= (fill_r < PAD_LEN_POS);
              if (fill_r == 6'(BLOCK_BYTES - 1)) begin
                go_r    <= 1'b1;
                state_r <= S_COMP;
              end else begin
                state_r <= S_PAD;
              end
            end
          end
        end
        S_PAD: begin
          blk_r[fill_r[5:2]][{~fill_r[1:0], 3'b000} +: 8] <= pad_byte;
          fill_r <= fill_r + 6'd1;
          if (fill_r == 6'(BLOCK_BYTES - 1)) begin
            go_r    <= 1'b1;
            state_r <= S_COMP;
          end
        end
        S_COMP: begin
          // the fold is made while done is high; wait for done to drop
          if (!go_r && !sts.busy && !sts.done) begin
            if (!fin_r) state_r <= S_IDLE;
            else if (!len_blk_r) begin
              // length did not fit: one more block of zeros and length
              len_blk_r <= 1'b1;
              state_r   <= S_PAD;
            end else begin
              widx_r   <= '0;
              ovalid_r <= 1'b1;
              state_r  <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (!out_stall) begin
            widx_r <= widx_r + 3'd1;
            if (widx_r == 3'd7) begin
              ovalid_r <= 1'b0;
              reinit_r <= 1'b1;
              fill_r   <= '0;
              total_r  <= '0;
              fin_r    <= 1'b0;
              state_r  <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `include "sha256_hash_engine_core_assert.svh"
  `SHA_ASSERT_IMP(a_stall_busy, sts.busy, in_stall)
  `SHA_ASSERT_IMP(a_out_emit, out_valid, state_r == S_EMIT)
  `SHA_ASSERT_NXT(a_last_reinit, out_valid && !out_stall && out_data.last_word,
                  !out_valid && state_r == S_IDLE)

endmodule
`default_nettype wire
